FILE: rtl/core/lwte_pkg.sv
package lwte_pkg;

  localparam int LineCapacity = 64;
  localparam int WordCapacity = 16;

  // line length counter holds up to LineCapacity-1
  localparam int LenW = $clog2(LineCapacity);
  // capture counter holds up to WordCapacity-1
  localparam int CntW = $clog2(WordCapacity);
  localparam int StoreDepth = WordCapacity - 1;
  localparam int StoreAw = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  localparam int TagLen = 5;
  localparam int MatchW = 3;

  localparam logic [7:0] ChCr   = 8'd13;
  localparam logic [7:0] ChLf   = 8'd10;
  localparam logic [7:0] ChZero = 8'd0;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  function automatic logic [7:0] tag_char(input logic [MatchW-1:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h77; // w
      3'd1:    ch = 8'h6f; // o
      3'd2:    ch = 8'h72; // r
      3'd3:    ch = 8'h64; // d
      3'd4:    ch = 8'h3d; // =
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/core/lwte_ram.sv
module lwte_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/line_word_tag_extractor.sv
// Channel  | Direction | Payload                              | Handshake
// rx       | in        | rx_byte_i                            | rx_valid_i / rx_ready_o
// word     | out       | word_char_o, char_index_o, is_last_o | word_valid_o / word_ready_i
//
// A non-terminator byte or an empty line is taken without leaving the idle state.
// A line end with a captured word of n characters reads the capture RAM once per character,
// its registered data loaded into the output register.
// Output stalls hold the emit loop; the rx side is blocked until the last character loads.
// rst_ni clears the line state and the output valid flag; the capture RAM needs no clearing.
module line_word_tag_extractor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rx_valid_i,
  output logic                           rx_ready_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           word_valid_o,
  input  logic                           word_ready_i,
  output logic [7:0]                     word_char_o,
  output logic [lwte_pkg::CntW-1:0]      char_index_o,
  output logic                           is_last_o
);

  lwte_pkg::state_e state_q, state_d;

  logic [lwte_pkg::LenW-1:0]   len_q, len_d;
  logic [lwte_pkg::MatchW-1:0] match_q, match_d;
  logic [lwte_pkg::CntW-1:0]   cap_q, cap_d;
  logic                        ended_q, ended_d;

  logic [lwte_pkg::CntW-1:0]   n_q, n_d;
  logic [lwte_pkg::CntW-1:0]   idx_q, idx_d;

  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_char_q, out_char_d;
  logic [lwte_pkg::CntW-1:0]   out_idx_q, out_idx_d;
  logic                        out_last_q, out_last_d;

  logic                        we;
  logic                        re;
  logic [lwte_pkg::CntW-1:0]   raddr;
  logic [7:0]                  rdata;

  logic rx_fire;
  logic is_term;
  logic load_out;
  logic char_last;

  assign rx_ready_o = (state_q == lwte_pkg::ST_IDLE);
  assign rx_fire    = rx_valid_i & rx_ready_o;
  assign is_term    = (rx_byte_i == lwte_pkg::ChCr) || (rx_byte_i == lwte_pkg::ChLf);
  assign load_out   = (state_q == lwte_pkg::ST_EMIT) && (!out_valid_q || word_ready_i);
  assign char_last  = ((idx_q + lwte_pkg::CntW'(1)) == n_q);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    match_d     = match_q;
    cap_d       = cap_q;
    ended_d     = ended_q;
    n_d         = n_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = idx_q;

    if (word_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      lwte_pkg::ST_IDLE: begin
        if (rx_fire) begin
          if (is_term) begin
            if (len_q != '0) begin
              // start the word read-out at entry 0
              if (cap_q != '0) begin
                re      = 1'b1;
                raddr   = '0;
                idx_d   = '0;
                n_d     = cap_q;
                state_d = lwte_pkg::ST_EMIT;
              end
              len_d   = '0;
              match_d = '0;
              cap_d   = '0;
              ended_d = 1'b0;
            end
          end else if (len_q == lwte_pkg::LenW'(lwte_pkg::LineCapacity - 1)) begin
            // overflow: drop the byte and empty the line
            len_d   = '0;
            match_d = '0;
            cap_d   = '0;
            ended_d = 1'b0;
          end else begin
            len_d = len_q + lwte_pkg::LenW'(1);
            if (!ended_q) begin
              if (rx_byte_i == lwte_pkg::ChZero) begin
                ended_d = 1'b1;
              end else if (match_q == lwte_pkg::MatchW'(lwte_pkg::TagLen)) begin
                if (cap_q != lwte_pkg::CntW'(lwte_pkg::WordCapacity - 1)) begin
                  we    = 1'b1;
                  cap_d = cap_q + lwte_pkg::CntW'(1);
                end
              end else if (rx_byte_i == lwte_pkg::tag_char(match_q)) begin
                match_d = match_q + lwte_pkg::MatchW'(1);
              end else if (rx_byte_i == lwte_pkg::tag_char('0)) begin
                match_d = lwte_pkg::MatchW'(1);
              end else begin
                match_d = '0;
              end
            end
          end
        end
      end
      lwte_pkg::ST_EMIT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_char_d  = rdata;
          out_idx_d   = idx_q;
          out_last_d  = char_last;
          if (char_last) begin
            state_d = lwte_pkg::ST_IDLE;
          end else begin
            // advance to the next stored character
            re    = 1'b1;
            raddr = idx_q + lwte_pkg::CntW'(1);
            idx_d = idx_q + lwte_pkg::CntW'(1);
          end
        end
      end
      default: begin
        state_d = lwte_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lwte_pkg::ST_IDLE;
      len_q       <= '0;
      match_q     <= '0;
      cap_q       <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      match_q     <= match_d;
      cap_q       <= cap_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  lwte_ram #(
    .Width (8),
    .Depth (lwte_pkg::StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cap_q[lwte_pkg::StoreAw-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (re),
    .raddr_i (raddr[lwte_pkg::StoreAw-1:0]),
    .rdata_o (rdata)
  );

  assign word_valid_o = out_valid_q;
  assign word_char_o  = out_char_q;
  assign char_index_o = out_idx_q;
  assign is_last_o    = out_last_q;

endmodule

FILE: tb/tb_line_word_tag_extractor.sv
module tb_line_word_tag_extractor;

  localparam int HalfPeriod = 10;
  localparam int LongHold   = 300;
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 40;

  localparam logic [7:0] TagText [lwte_pkg::TagLen] = '{8'h77, 8'h6f, 8'h72, 8'h64, 8'h3d};

  typedef struct packed {
    logic [7:0]                ch;
    logic [lwte_pkg::CntW-1:0] idx;
    logic                      last;
  } word_char_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      rx_valid_i;
  logic                      rx_ready_o;
  logic [7:0]                rx_byte_i;
  logic                      word_valid_o;
  logic                      word_ready_i;
  logic [7:0]                word_char_o;
  logic [lwte_pkg::CntW-1:0] char_index_o;
  logic                      is_last_o;

  line_word_tag_extractor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .word_valid_o(word_valid_o),
    .word_ready_i(word_ready_i),
    .word_char_o (word_char_o),
    .char_index_o(char_index_o),
    .is_last_o   (is_last_o)
  );

  // line tracking state, mirrors the block
  logic [lwte_pkg::LenW-1:0]   line_len;
  logic [lwte_pkg::MatchW-1:0] match_pos;
  logic [lwte_pkg::CntW-1:0]   cap_cnt;
  logic                        text_end;
  logic [7:0]                  cap_store [lwte_pkg::StoreDepth];

  word_char_t pending_chars [$];
  word_char_t want;
  int         err_cnt;
  int         rx_words;
  int         quiet_cycles;
  bit         idle_en;
  bit         hold_req;

  always begin
    clk_i = 1'b0;
    #HalfPeriod;
    clk_i = 1'b1;
    #HalfPeriod;
  end

  function automatic void clear_line_state();
    line_len  = '0;
    match_pos = '0;
    cap_cnt   = '0;
    text_end  = 1'b0;
  endfunction

  function automatic void track_line_byte(input logic [7:0] b);
    word_char_t wc;
    if (b == lwte_pkg::ChCr || b == lwte_pkg::ChLf) begin
      if (line_len != 0) begin
        for (int i = 0; i < cap_cnt; i++) begin
          wc.ch   = cap_store[i];
          wc.idx  = i[lwte_pkg::CntW-1:0];
          wc.last = (i == cap_cnt - 1);
          pending_chars.push_back(wc);
        end
        clear_line_state();
      end
      return;
    end
    // a full line drops the byte and starts afresh
    if (line_len >= lwte_pkg::LineCapacity - 1) begin
      clear_line_state();
      return;
    end
    line_len++;
    if (text_end) return;
    if (b == lwte_pkg::ChZero) begin
      text_end = 1'b1;
      return;
    end
    if (match_pos >= lwte_pkg::TagLen) begin
      if (cap_cnt < lwte_pkg::StoreDepth) begin
        cap_store[cap_cnt] = b;
        cap_cnt++;
      end
    end else if (b == TagText[match_pos]) begin
      match_pos++;
    end else begin
      match_pos = (b == TagText[0]) ? 3'd1 : 3'd0;
    end
  endfunction

  // any byte that neither ends a line nor ends the text
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == lwte_pkg::ChCr || b == lwte_pkg::ChLf);
    return b;
  endfunction

  // text byte with a bias towards the letters of the tag
  function automatic logic [7:0] pick_tag_noise();
    if ($urandom_range(0, 2) == 0) return TagText[$urandom_range(0, lwte_pkg::TagLen - 1)];
    return pick_text_byte();
  endfunction

  function automatic logic [7:0] pick_line_end();
    return $urandom_range(0, 1) ? lwte_pkg::ChCr : lwte_pkg::ChLf;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      rx_valid_i = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    rx_valid_i = 1'b1;
    rx_byte_i  = b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    track_line_byte(b);
    rx_words++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_filler(input int n);
    repeat (n) send_byte(pick_text_byte());
  endtask

  task automatic test_tag_search();
    send_text("word=hi\n");
    // a doubled w restarts the search on the second one
    send_text("wword=");
    send_byte(8'hff);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(lwte_pkg::ChCr);
    send_text("word=word=z\n");
  endtask

  task automatic test_empty_and_zero();
    send_byte(lwte_pkg::ChLf);
    send_byte(lwte_pkg::ChCr);
    send_text("ab\r");
    send_text("word=\n");
    send_text("word=a");
    send_byte(lwte_pkg::ChZero);
    send_text("b\r");
    send_text("wo");
    send_byte(lwte_pkg::ChZero);
    send_text("rd=x\n");
  endtask

  task automatic test_line_limits();
    // one byte too many empties the line, the captured word is lost
    send_text("word=");
    send_filler(lwte_pkg::LineCapacity - 1 - lwte_pkg::TagLen);
    send_byte(pick_text_byte());
    send_byte(lwte_pkg::ChCr);
    send_text("word=k\r");
  endtask

  task automatic test_backpressure();
    // longest line that still ends cleanly, full word held off at the receiver
    hold_req = 1'b1;
    send_text("word=");
    send_filler(lwte_pkg::LineCapacity - 1 - lwte_pkg::TagLen);
    send_byte(pick_line_end());
  endtask

  task automatic send_random_line();
    int n;
    if ($urandom_range(0, 9) < 7) begin
      n = $urandom_range(0, 6);
      repeat (n) send_byte(pick_tag_noise());
      send_text("word=");
      n = $urandom_range(1, 18);
      repeat (n) send_byte(($urandom_range(0, 19) == 0) ? lwte_pkg::ChZero : pick_text_byte());
      if ($urandom_range(0, 3) == 0) send_text("word=q");
    end else begin
      n = $urandom_range(0, 10);
      repeat (n) send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : pick_tag_noise());
    end
    send_byte(pick_line_end());
  endtask

  task automatic test_random_lines();
    int start;
    start = rx_words;
    while (rx_words < start + 12) begin
      // finish with both sides running flat out
      if (rx_words >= start + 4) idle_en = 1'b0;
      send_random_line();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && word_valid_o && word_ready_i) begin
      if (pending_chars.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected word char %h idx %0d last %b",
                   word_char_o, char_index_o, is_last_o);
      end else begin
        want = pending_chars.pop_front();
        if (word_char_o !== want.ch || char_index_o !== want.idx || is_last_o !== want.last)
        begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("word char mismatch: exp %h/%0d/%b got %h/%0d/%b",
                     want.ch, want.idx, want.last, word_char_o, char_index_o, is_last_o);
        end
      end
    end
  end

  // receiver side, with random stalls and one long hold-off on request
  initial begin
    int hold_cnt;
    word_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req     = 1'b0;
        word_ready_i = 1'b0;
        hold_cnt     = 0;
        while (hold_cnt < LongHold) begin
          @(negedge clk_i);
          hold_cnt++;
        end
        word_ready_i = 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        word_ready_i = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        word_ready_i = 1'b1;
      end else begin
        word_ready_i = 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((rx_valid_i && rx_ready_o) || (word_valid_o && word_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    rx_valid_i   = 1'b0;
    rx_byte_i    = '0;
    idle_en      = 1'b0;
    hold_req     = 1'b0;
    err_cnt      = 0;
    rx_words     = 0;
    clear_line_state();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  = 1'b1;
    idle_en = 1'b1;

    test_tag_search();
    test_empty_and_zero();
    test_line_limits();
    test_backpressure();
    test_random_lines();

    @(negedge clk_i);
    rx_valid_i = 1'b0;
    wait (pending_chars.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: line_word_tag_extractor.f
rtl/core/lwte_pkg.sv
rtl/core/lwte_ram.sv
rtl/core/line_word_tag_extractor.sv
tb/tb_line_word_tag_extractor.sv
